FILE: sv/fdt_pkg.sv
package fdt_pkg;

  localparam int unsigned OffsetBits = 32;

  typedef logic [OffsetBits-1:0] off_t;

  localparam logic [31:0] MagicWord    = 32'hd00dfeed;
  localparam logic [31:0] TokBeginNode = 32'h0000_0001;
  localparam logic [31:0] TokEndNode   = 32'h0000_0002;
  localparam logic [31:0] TokProp      = 32'h0000_0003;
  localparam logic [31:0] TokNop       = 32'h0000_0004;
  localparam logic [31:0] TokEnd       = 32'h0000_0009;

  localparam int unsigned SkipBits = 30;

  typedef enum logic [2:0] {
    PhHeader = 3'd0,
    PhSeek   = 3'd1,
    PhToken  = 3'd2,
    PhName   = 3'd3,
    PhPlen   = 3'd4,
    PhPname  = 3'd5,
    PhValue  = 3'd6,
    PhDone   = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KindProp    = 2'd0,
    KindEnd     = 2'd1,
    KindMagic   = 2'd2,
    KindUnknown = 2'd3
  } kind_e;

  typedef struct packed {
    logic [31:0] blob_word;
    logic        first_word;
  } in_beat_t;

  typedef struct packed {
    kind_e       record_kind;
    logic [31:0] node_name_offset;
    logic [31:0] property_offset;
    logic [31:0] property_name_offset;
    logic [31:0] value_length;
  } out_beat_t;

endpackage

FILE: sv/fdt_structure_walker_top.sv
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_ready_o   | fdt_pkg::in_beat_t  (blob word, first flag)
// out     | output    | out_valid_o / out_ready_i | fdt_pkg::out_beat_t (one record)
//
// One blob word per cycle while in_ready_o is high; the parser state updates in the cycle the beat is taken.
// Each record is registered into a two-entry output buffer, which
// holds records while out stalls, and in_ready_o drops only when both are full.
// Reset (async, active low) puts the parser in the header phase at offset 0.
module fdt_structure_walker_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fdt_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fdt_pkg::out_beat_t out_data_o
);

  fdt_pkg::phase_e phase_q, phase_d;
  fdt_pkg::off_t   wpos_q, wpos_d;
  fdt_pkg::off_t   struct_q, struct_d;
  fdt_pkg::off_t   strings_q, strings_d;
  fdt_pkg::off_t   node_q, node_d;
  fdt_pkg::off_t   pprop_q, pprop_d;
  logic [31:0]     plen_q, plen_d;
  logic [fdt_pkg::SkipBits-1:0] skip_q, skip_d;

  logic               v0_q, v0_d, v1_q, v1_d;
  fdt_pkg::out_beat_t d0_q, d0_d, d1_q, d1_d;

  logic               in_fire;
  logic               res_valid;
  fdt_pkg::out_beat_t res;

  fdt_pkg::phase_e phase_c;
  fdt_pkg::off_t   pos, wpos_c, struct_c, strings_c, node_c, pprop_c;
  logic [31:0]     plen_c;
  logic [fdt_pkg::SkipBits-1:0] skip_c, skip_dec;
  logic [31:0]     w;
  fdt_pkg::off_t   w_off;
  logic            zero_byte;
  logic [fdt_pkg::SkipBits:0] words;
  logic [fdt_pkg::SkipBits-1:0] words_sat;

  assign in_ready_o = !v1_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign w          = in_data_i.blob_word;
  assign w_off      = w[fdt_pkg::OffsetBits-1:0];
  assign zero_byte  = (w[31:24] == 8'h00) || (w[23:16] == 8'h00) ||
                      (w[15:8] == 8'h00) || (w[7:0] == 8'h00);
  assign words      = {1'b0, plen_c[31:2]} +
                      (fdt_pkg::SkipBits+1)'(plen_c[1:0] != 2'b00);
  assign words_sat  = words[fdt_pkg::SkipBits] ? '1 : words[fdt_pkg::SkipBits-1:0];
  assign skip_dec   = (skip_c != '0) ? skip_c - 1'b1 : skip_c;

  always_comb begin
    if (in_data_i.first_word) begin
      phase_c   = fdt_pkg::PhHeader;
      wpos_c    = '0;
      struct_c  = '0;
      strings_c = '0;
      node_c    = '0;
      pprop_c   = '0;
      plen_c    = '0;
      skip_c    = '0;
    end else begin
      phase_c   = phase_q;
      wpos_c    = wpos_q;
      struct_c  = struct_q;
      strings_c = strings_q;
      node_c    = node_q;
      pprop_c   = pprop_q;
      plen_c    = plen_q;
      skip_c    = skip_q;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    wpos_d    = wpos_q;
    struct_d  = struct_q;
    strings_d = strings_q;
    node_d    = node_q;
    pprop_d   = pprop_q;
    plen_d    = plen_q;
    skip_d    = skip_q;
    res_valid = 1'b0;
    pos       = wpos_c;
    res.record_kind          = fdt_pkg::KindEnd;
    res.node_name_offset     = 32'(node_c);
    res.property_offset      = 32'(pos);
    res.property_name_offset = '0;
    res.value_length         = '0;

    if (in_fire) begin
      phase_d   = phase_c;
      wpos_d    = wpos_c;
      struct_d  = struct_c;
      strings_d = strings_c;
      node_d    = node_c;
      pprop_d   = pprop_c;
      plen_d    = plen_c;
      skip_d    = skip_c;
      if (phase_c != fdt_pkg::PhDone) begin
        wpos_d = pos + fdt_pkg::off_t'(4);
        if (phase_c == fdt_pkg::PhSeek && pos == struct_c) begin
          phase_d = fdt_pkg::PhToken;
        end
        unique case (phase_d)
          fdt_pkg::PhHeader: begin
            if (pos == fdt_pkg::off_t'(0)) begin
              if (w != fdt_pkg::MagicWord) begin
                res_valid            = 1'b1;
                res.record_kind      = fdt_pkg::KindMagic;
                res.property_offset  = '0;
                phase_d              = fdt_pkg::PhDone;
              end
            end else if (pos == fdt_pkg::off_t'(8)) begin
              struct_d = {w_off[fdt_pkg::OffsetBits-1:2], 2'b00};
            end else if (pos == fdt_pkg::off_t'(12)) begin
              strings_d = w_off;
              phase_d   = (struct_c <= fdt_pkg::off_t'(16)) ? fdt_pkg::PhToken
                                                           : fdt_pkg::PhSeek;
            end
          end
          fdt_pkg::PhToken: begin
            priority if (w == fdt_pkg::TokBeginNode) begin
              node_d  = wpos_d;
              phase_d = fdt_pkg::PhName;
            end else if (w == fdt_pkg::TokProp) begin
              pprop_d = wpos_d;
              phase_d = fdt_pkg::PhPlen;
            end else if (w == fdt_pkg::TokEndNode || w == fdt_pkg::TokNop) begin
              phase_d = fdt_pkg::PhToken;
            end else if (w == fdt_pkg::TokEnd) begin
              res_valid       = 1'b1;
              res.record_kind = fdt_pkg::KindEnd;
              phase_d         = fdt_pkg::PhDone;
            end else begin
              res_valid       = 1'b1;
              res.record_kind = fdt_pkg::KindUnknown;
              phase_d         = fdt_pkg::PhDone;
            end
          end
          fdt_pkg::PhName: begin
            if (zero_byte) begin
              phase_d = fdt_pkg::PhToken;
            end
          end
          fdt_pkg::PhPlen: begin
            plen_d  = w;
            phase_d = fdt_pkg::PhPname;
          end
          fdt_pkg::PhPname: begin
            res_valid                = 1'b1;
            res.record_kind          = fdt_pkg::KindProp;
            res.property_offset      = 32'(pprop_c);
            res.property_name_offset = 32'(fdt_pkg::off_t'(strings_c + w_off));
            res.value_length         = plen_c;
            skip_d                   = words_sat;
            phase_d = (words_sat != '0) ? fdt_pkg::PhValue : fdt_pkg::PhToken;
          end
          fdt_pkg::PhValue: begin
            skip_d = skip_dec;
            if (skip_dec == '0) begin
              phase_d = fdt_pkg::PhToken;
            end
          end
          default: begin
            phase_d = phase_d;
          end
        endcase
      end
    end
  end

  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    d0_d = d0_q;
    d1_d = d1_q;
    if (v0_q && out_ready_i) begin
      v0_d = v1_q;
      d0_d = d1_q;
      v1_d = 1'b0;
    end
    if (res_valid) begin
      if (!v0_d) begin
        v0_d = 1'b1;
        d0_d = res;
      end else begin
        v1_d = 1'b1;
        d1_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= fdt_pkg::PhHeader;
      wpos_q    <= '0;
      struct_q  <= '0;
      strings_q <= '0;
      node_q    <= '0;
      pprop_q   <= '0;
      plen_q    <= '0;
      skip_q    <= '0;
      v0_q      <= 1'b0;
      v1_q      <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      wpos_q    <= wpos_d;
      struct_q  <= struct_d;
      strings_q <= strings_d;
      node_q    <= node_d;
      pprop_q   <= pprop_d;
      plen_q    <= plen_d;
      skip_q    <= skip_d;
      v0_q      <= v0_d;
      v1_q      <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d0_q <= d0_d;
    d1_q <= d1_d;
  end

  assign out_valid_o = v0_q;
  assign out_data_o  = d0_q;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int Items      = 1300;
  localparam int HoldCycles = 300;
  localparam int StallLimit = 2000;
  localparam int DrainWait  = 16;
  localparam int MaxReports = 10;

  class record_scoreboard;
    fdt_pkg::phase_e              phase;
    fdt_pkg::off_t                next_pos;
    fdt_pkg::off_t                struct_start;
    fdt_pkg::off_t                strings_start;
    fdt_pkg::off_t                cur_node;
    fdt_pkg::off_t                prop_start;
    logic [31:0]                  prop_len;
    logic [fdt_pkg::SkipBits-1:0] skip_left;
    fdt_pkg::out_beat_t           pending_records[$];
    int                           errors;
    int                           words_used;
    int                           prop_records;
    int                           final_records;

    function void clear();
      phase         = fdt_pkg::PhHeader;
      next_pos      = '0;
      struct_start  = '0;
      strings_start = '0;
      cur_node      = '0;
      prop_start    = '0;
      prop_len      = '0;
      skip_left     = '0;
    endfunction

    function void emit_final(fdt_pkg::kind_e kind, fdt_pkg::off_t at);
      fdt_pkg::out_beat_t rec;
      rec.record_kind          = kind;
      rec.node_name_offset     = cur_node;
      rec.property_offset      = at;
      rec.property_name_offset = '0;
      rec.value_length         = '0;
      pending_records.push_back(rec);
      phase = fdt_pkg::PhDone;
    endfunction

    function void take_word(fdt_pkg::in_beat_t b);
      fdt_pkg::off_t      pos;
      logic [31:0]        w;
      logic [32:0]        span;
      fdt_pkg::out_beat_t rec;
      w = b.blob_word;
      if (b.first_word) clear();
      if (phase == fdt_pkg::PhDone) return;
      words_used++;
      pos      = next_pos;
      next_pos = pos + fdt_pkg::off_t'(4);
      if (phase == fdt_pkg::PhSeek && pos == struct_start) phase = fdt_pkg::PhToken;
      case (phase)
        fdt_pkg::PhHeader: begin
          if (pos == 0) begin
            if (w != fdt_pkg::MagicWord) emit_final(fdt_pkg::KindMagic, '0);
          end else if (pos == 8) begin
            struct_start = fdt_pkg::off_t'(w) & ~fdt_pkg::off_t'(3);
          end else if (pos == 12) begin
            strings_start = fdt_pkg::off_t'(w);
            phase = (struct_start <= 16) ? fdt_pkg::PhToken : fdt_pkg::PhSeek;
          end
        end
        fdt_pkg::PhToken: begin
          if (w == fdt_pkg::TokBeginNode) begin
            cur_node = next_pos;
            phase    = fdt_pkg::PhName;
          end else if (w == fdt_pkg::TokProp) begin
            prop_start = next_pos;
            phase      = fdt_pkg::PhPlen;
          end else if (w == fdt_pkg::TokEndNode || w == fdt_pkg::TokNop) begin
          end else if (w == fdt_pkg::TokEnd) begin
            emit_final(fdt_pkg::KindEnd, pos);
          end else begin
            emit_final(fdt_pkg::KindUnknown, pos);
          end
        end
        fdt_pkg::PhName: begin
          if (w[31:24] == 0 || w[23:16] == 0 || w[15:8] == 0 || w[7:0] == 0)
            phase = fdt_pkg::PhToken;
        end
        fdt_pkg::PhPlen: begin
          prop_len = w;
          phase    = fdt_pkg::PhPname;
        end
        fdt_pkg::PhPname: begin
          span = ({1'b0, prop_len} + 33'd3) >> 2;
          if (span > {fdt_pkg::SkipBits{1'b1}}) skip_left = {fdt_pkg::SkipBits{1'b1}};
          else skip_left = span[fdt_pkg::SkipBits-1:0];
          rec.record_kind          = fdt_pkg::KindProp;
          rec.node_name_offset     = cur_node;
          rec.property_offset      = prop_start;
          rec.property_name_offset = strings_start + fdt_pkg::off_t'(w);
          rec.value_length         = prop_len;
          pending_records.push_back(rec);
          phase = (skip_left != 0) ? fdt_pkg::PhValue : fdt_pkg::PhToken;
        end
        fdt_pkg::PhValue: begin
          if (skip_left != 0) skip_left--;
          if (skip_left == 0) phase = fdt_pkg::PhToken;
        end
        default: begin
        end
      endcase
    endfunction

    function void check_record(fdt_pkg::out_beat_t got);
      fdt_pkg::out_beat_t want;
      if (pending_records.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("unexpected record: kind %0d node %h prop %h name %h len %h",
                   got.record_kind, got.node_name_offset, got.property_offset,
                   got.property_name_offset, got.value_length);
        return;
      end
      want = pending_records.pop_front();
      if (want.record_kind == fdt_pkg::KindProp) prop_records++;
      else final_records++;
      if (got.record_kind !== want.record_kind ||
          got.node_name_offset !== want.node_name_offset ||
          got.property_offset !== want.property_offset ||
          got.property_name_offset !== want.property_name_offset ||
          got.value_length !== want.value_length) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("record mismatch: exp kind %0d node %h prop %h name %h len %h",
                   want.record_kind, want.node_name_offset, want.property_offset,
                   want.property_name_offset, want.value_length);
          $display("                 got kind %0d node %h prop %h name %h len %h",
                   got.record_kind, got.node_name_offset, got.property_offset,
                   got.property_name_offset, got.value_length);
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  fdt_pkg::in_beat_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  fdt_pkg::out_beat_t out_data_o;

  record_scoreboard records;
  logic [31:0]      blob_q[$];
  int               in_idle_pct;
  int               out_idle_pct;
  int               hold_requests;
  int               hold_served;
  int               hold_left;
  int               stall_cycles;
  int               blobs_sent;
  int               words_sent;

  fdt_structure_walker_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic push_word(input logic [31:0] w, input bit restart);
    fdt_pkg::in_beat_t b;
    b.blob_word  = w;
    b.first_word = restart;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    records.take_word(b);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_blob(input bit restart, input bit noisy);
    foreach (blob_q[i])
      push_word(blob_q[i], (i == 0) ? restart : (noisy && $urandom_range(199) == 0));
    blobs_sent++;
  endtask

  function automatic logic [31:0] name_body();
    return {8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
            8'($urandom_range(255, 1)), 8'($urandom_range(255, 1))};
  endfunction

  task automatic add_prop(input bit huge);
    logic [31:0] len;
    if (huge) len = $urandom | 32'h8000_0000;
    else if ($urandom_range(15) == 0) len = $urandom_range(64);
    else len = $urandom_range(12);
    blob_q.push_back(fdt_pkg::TokProp);
    blob_q.push_back(len);
    blob_q.push_back(($urandom_range(3) == 0) ? $urandom : $urandom_range(255));
    if (huge) repeat ($urandom_range(3)) blob_q.push_back($urandom);
    else repeat ((len + 3) / 4) blob_q.push_back($urandom);
  endtask

  task automatic add_node(input int depth, input bit noisy);
    logic [31:0] w;
    int          pick;
    blob_q.push_back(fdt_pkg::TokBeginNode);
    repeat ($urandom_range(2)) blob_q.push_back(name_body());
    w = $urandom;
    w[8*$urandom_range(3) +: 8] = 8'h00;
    blob_q.push_back(w);
    repeat ($urandom_range(4)) begin
      pick = $urandom_range(99);
      if (noisy && pick < 4) blob_q.push_back($urandom);
      else if (pick < 60) add_prop(1'b0);
      else if (pick < 75 || depth >= 2) blob_q.push_back(fdt_pkg::TokNop);
      else add_node(depth + 1, noisy);
    end
    blob_q.push_back(fdt_pkg::TokEndNode);
  endtask

  task automatic gen_blob();
    int          flavor;
    logic [31:0] so;
    flavor = $urandom_range(99);
    blob_q.delete();
    blob_q.push_back((flavor < 5) ? $urandom : fdt_pkg::MagicWord);
    blob_q.push_back($urandom);
    so = ($urandom_range(3) == 0) ? $urandom_range(19) : $urandom_range(72, 17);
    blob_q.push_back(so);
    blob_q.push_back(($urandom_range(1) == 0) ? $urandom : $urandom_range(4096));
    for (int p = 16; p < int'(so & ~32'd3); p += 4) blob_q.push_back($urandom);
    if (flavor >= 5 && flavor < 10) repeat ($urandom_range(3, 1)) blob_q.push_back($urandom);
    add_node(0, flavor < 20);
    if (flavor >= 10 && flavor < 14) add_prop(1'b1);
    else if (flavor >= 14 && flavor < 18) begin
    end else blob_q.push_back(fdt_pkg::TokEnd);
    repeat ($urandom_range(3)) blob_q.push_back($urandom);
  endtask

  // receiver: random stalls plus on-request long hold-off
  initial begin
    out_ready_i = 1'b0;
    hold_served = 0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) records.check_record(out_data_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no beat for %0d cycles", StallLimit);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    records = new;
    records.clear();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    in_idle_pct   = 33;
    out_idle_pct  = 67;
    hold_requests = 0;
    stall_cycles  = 0;
    blobs_sent    = 0;
    words_sent    = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // first blob without first_word; property ahead of any node, strings wrap
    blob_q = '{fdt_pkg::MagicWord, 32'hFFFF_FFFF, 32'd8, 32'hFFFF_FFF0,
               fdt_pkg::TokProp, 32'd0, 32'h20,
               fdt_pkg::TokBeginNode, 32'h6100_0000,
               fdt_pkg::TokProp, 32'd5, 32'd4, 32'h0, 32'hFFFF_FFFF,
               fdt_pkg::TokNop, fdt_pkg::TokEndNode, fdt_pkg::TokEnd, 32'h0};
    send_blob(1'b0, 1'b0);
    blob_q = '{32'h0};
    send_blob(1'b1, 1'b0);
    // unaligned structure offset, saturating value skip, then restart
    blob_q = '{fdt_pkg::MagicWord, 32'h0, 32'h13, 32'h0, fdt_pkg::TokProp,
               32'hFFFF_FFFF, 32'h8};
    send_blob(1'b1, 1'b0);

    while (words_sent < Items) begin
      if (words_sent >= 2 * Items / 3) begin
        if (in_idle_pct != 0 || out_idle_pct != 0) begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
          hold_requests++;
        end
      end else if (words_sent >= Items / 3) begin
        in_idle_pct  = 67;
        out_idle_pct = 33;
      end
      gen_blob();
      send_blob($urandom_range(19) != 0, 1'b1);
    end
    in_valid_i <= 1'b0;

    while (records.pending_records.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("%0d blobs, %0d words parsed under three stall mixes and a long output hold",
             blobs_sent, records.words_used);
    $display("%0d property and %0d final records checked",
             records.prop_records, records.final_records);
    if (records.errors == 0 && records.pending_records.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d errors, %0d records never seen", records.errors,
               records.pending_records.size());
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
